// ----- hw/rtl/rational_arithmetic_unit_macros.svh -----
// Assertion macros used by the checker file.
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define RAU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ----- hw/rtl/rau_pkg.sv -----
// Package: word types and action codes of the rational arithmetic unit.
package rau_pkg;
   localparam int VALUE_WIDTH = 16;
   localparam int DEN_WIDTH   = VALUE_WIDTH - 1;
   localparam int PROD_WIDTH  = 2 * VALUE_WIDTH + 2;

   localparam logic [3:0] ACT_ADD = 4'd0;
   localparam logic [3:0] ACT_SUB = 4'd1;
   localparam logic [3:0] ACT_MUL = 4'd2;
   localparam logic [3:0] ACT_DIV = 4'd3;
   localparam logic [3:0] ACT_EQ  = 4'd4;
   localparam logic [3:0] ACT_GT  = 4'd5;
   localparam logic [3:0] ACT_LT  = 4'd6;
   localparam logic [3:0] ACT_GE  = 4'd7;
   localparam logic [3:0] ACT_LE  = 4'd8;

   localparam logic [1:0] ERR_OK       = 2'd0;
   localparam logic [1:0] ERR_DIV_ZERO = 2'd1;
   localparam logic [1:0] ERR_OVERFLOW = 2'd2;

   typedef struct packed {
      logic [3:0]                    action;
      logic signed [VALUE_WIDTH-1:0] a_num;
      logic [DEN_WIDTH-1:0]          a_den;
      logic signed [VALUE_WIDTH-1:0] b_num;
      logic [DEN_WIDTH-1:0]          b_den;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] res_num;
      logic [DEN_WIDTH-1:0]          res_den;
      logic                          cmp_true;
      logic [1:0]                    error_code;
   } rsp_type;
endpackage

// ----- hw/rtl/rau_divider.sv -----
// Shared restoring divider: one quotient bit per cycle over PROD_WIDTH bits.
module rau_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [rau_pkg::PROD_WIDTH-1:0] dividend,
   input  logic [rau_pkg::PROD_WIDTH-1:0] divisor,
   output logic                           done,
   output logic [rau_pkg::PROD_WIDTH-1:0] quotient,
   output logic [rau_pkg::PROD_WIDTH-1:0] remainder
);
   localparam int W  = rau_pkg::PROD_WIDTH;
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  quo_ff, quo_in, rem_ff, rem_in, dvs_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [W:0]    trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         trial  = {rem_ff, quo_ff[W-1]} - {1'b0, dvs_ff};
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[W-2:0], quo_ff[W-1]};
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) dvs_ff <= divisor;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

// ----- hw/rtl/rational_arithmetic_unit.sv -----
// Rational arithmetic unit: add, subtract, multiply, divide, compare fractions.
// Bad words and compares finish without the divider; arithmetic multiplies,
// runs Euclid modulo steps for the gcd, then divides numerator and denominator.
// Throughput: one word at a time; req_stall stays high while a word is in work,
// a finished result waits in the output register. The shared 34-bit restoring
// divider (one bit a cycle) does every division. Reset: synchronous, active high.
module rational_arithmetic_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rau_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rau_pkg::rsp_type rsp_data
);
   localparam int VW = rau_pkg::VALUE_WIDTH;
   localparam int DW = rau_pkg::DEN_WIDTH;
   localparam int PW = rau_pkg::PROD_WIDTH;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL1, ST_MUL2, ST_COMBINE, ST_GCD_SEED, ST_GCD_START, ST_GCD_WAIT,
      ST_RED_NUM, ST_RED_NUM_WAIT, ST_RED_DEN, ST_RED_DEN_WAIT, ST_FINISH, ST_OUT
   } state_type;

   state_type                state_ff;
   rau_pkg::req_type         req_ff;
   logic signed [PW-1:0]     p1_ff, p2_ff, num_ff, den_ff;
   logic [PW-1:0]            gx_ff, gy_ff, g_ff, qn_ff;
   logic                     neg_ff;
   rau_pkg::rsp_type         res_ff;
   rau_pkg::rsp_type         rsp_ff;
   logic                     rsp_valid_ff;

   // shared multiplier operands (one 17x17 signed product per cycle)
   logic signed [VW:0]       mul_a, mul_b;
   logic signed [PW-1:0]     mul_p;

   logic                     div_start, div_done;
   logic [PW-1:0]            div_n, div_d, div_q, div_r;

   rau_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_n), .divisor(div_d),
      .done(div_done), .quotient(div_q), .remainder(div_r)
   );

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_MUL1: begin
            mul_a = (VW+1)'(req_ff.a_num);
            mul_b = (req_ff.action == rau_pkg::ACT_MUL) ? (VW+1)'(req_ff.b_num)
                    : $signed({2'b0, req_ff.b_den});
         end
         ST_MUL2: begin
            if (req_ff.action == rau_pkg::ACT_MUL) begin
               mul_a = $signed({2'b0, req_ff.a_den});
               mul_b = $signed({2'b0, req_ff.b_den});
            end else begin
               mul_a = (VW+1)'(req_ff.b_num);
               mul_b = $signed({2'b0, req_ff.a_den});
            end
         end
         default: ;
      endcase
      mul_p = PW'(mul_a * mul_b);
   end

   // divider feed: Euclid steps take larger mod smaller, then reduce
   always_comb begin
      div_start = 1'b0;
      div_n     = '0;
      div_d     = '0;
      unique case (state_ff)
         ST_GCD_START: begin
            div_start = 1'b1;
            div_n = (gx_ff > gy_ff) ? gx_ff : gy_ff;
            div_d = (gx_ff > gy_ff) ? gy_ff : gx_ff;
         end
         ST_RED_NUM: begin
            div_start = 1'b1;
            div_n = num_ff[PW-1] ? PW'(-num_ff) : num_ff;
            div_d = g_ff;
         end
         ST_RED_DEN: begin
            div_start = 1'b1;
            div_n = den_ff;
            div_d = g_ff;
         end
         default: ;
      endcase
   end

   logic lt_w, eq_w, hold_w, bad_w;
   assign lt_w   = p1_ff < p2_ff;
   assign eq_w   = p1_ff == p2_ff;
   assign hold_w = rsp_valid_ff && rsp_stall;
   // zero denominator on either side, or division by a zero fraction
   assign bad_w  = req_ff.a_den == '0 || req_ff.b_den == '0 ||
                   (req_ff.action == rau_pkg::ACT_DIV && req_ff.b_num == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop the result word once taken, unless a new one loads now
         if (state_ff != ST_OUT && rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (req_valid) begin
               req_ff   <= req_data;
               state_ff <= ST_MUL1;
            end
            ST_MUL1: begin
               // hold left product, screen bad words
               p1_ff             <= mul_p;
               res_ff.res_num    <= '0;
               res_ff.res_den    <= '0;
               res_ff.cmp_true   <= 1'b0;
               res_ff.error_code <= (req_ff.action <= rau_pkg::ACT_LE && bad_w) ?
                                    rau_pkg::ERR_DIV_ZERO : rau_pkg::ERR_OK;
               if (req_ff.action > rau_pkg::ACT_LE || bad_w) state_ff <= ST_OUT;
               else state_ff <= ST_MUL2;
            end
            ST_MUL2: begin
               p2_ff    <= mul_p;
               state_ff <= ST_COMBINE;
            end
            ST_COMBINE: begin
               state_ff <= ST_GCD_SEED;
               neg_ff   <= 1'b0;
               unique case (req_ff.action)
                  rau_pkg::ACT_ADD, rau_pkg::ACT_SUB: begin
                     num_ff <= (req_ff.action == rau_pkg::ACT_ADD) ? p1_ff + p2_ff
                               : p1_ff - p2_ff;
                     den_ff <= PW'({1'b0, req_ff.a_den}) * PW'({1'b0, req_ff.b_den});
                  end
                  rau_pkg::ACT_MUL: begin
                     num_ff <= p1_ff;
                     den_ff <= p2_ff;
                  end
                  rau_pkg::ACT_DIV: begin
                     // move divisor sign to numerator
                     num_ff <= p2_ff[PW-1] ? -p1_ff : p1_ff;
                     den_ff <= p2_ff[PW-1] ? -p2_ff : p2_ff;
                  end
                  default: begin
                     res_ff.cmp_true <=
                        (req_ff.action == rau_pkg::ACT_EQ && eq_w) ||
                        (req_ff.action == rau_pkg::ACT_GT && !lt_w && !eq_w) ||
                        (req_ff.action == rau_pkg::ACT_LT && lt_w) ||
                        (req_ff.action == rau_pkg::ACT_GE && !lt_w) ||
                        (req_ff.action == rau_pkg::ACT_LE && (lt_w || eq_w));
                     state_ff <= ST_OUT;
                  end
               endcase
            end
            ST_GCD_SEED: begin
               // seed Euclid operands; zero result skips to 0/1 with gcd = den
               gx_ff    <= num_ff[PW-1] ? PW'(-num_ff) : num_ff;
               gy_ff    <= den_ff;
               g_ff     <= den_ff;
               state_ff <= (num_ff == '0) ? ST_RED_NUM : ST_GCD_START;
            end
            ST_GCD_START: state_ff <= ST_GCD_WAIT;
            ST_GCD_WAIT: if (div_done) begin
               // replace larger by remainder
               if (gx_ff > gy_ff) gx_ff <= div_r; else gy_ff <= div_r;
               if (div_r == '0) begin
                  g_ff     <= (gx_ff > gy_ff) ? gy_ff : gx_ff;
                  state_ff <= ST_RED_NUM;
               end else state_ff <= ST_GCD_START;
            end
            ST_RED_NUM: begin
               neg_ff   <= num_ff[PW-1];
               state_ff <= ST_RED_NUM_WAIT;
            end
            ST_RED_NUM_WAIT: if (div_done) begin
               qn_ff    <= div_q;
               state_ff <= ST_RED_DEN;
            end
            ST_RED_DEN: state_ff <= ST_RED_DEN_WAIT;
            ST_RED_DEN_WAIT: if (div_done) begin
               den_ff   <= div_q;
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               // range check on reduced terms
               if ((!neg_ff && qn_ff > PW'((1 << (VW-1)) - 1)) ||
                   (neg_ff && qn_ff > PW'(1 << (VW-1))) ||
                   den_ff > PW'((1 << (VW-1)) - 1))
                  res_ff.error_code <= rau_pkg::ERR_OVERFLOW;
               else begin
                  res_ff.res_num <= neg_ff ? -VW'(qn_ff) : VW'(qn_ff);
                  res_ff.res_den <= DW'(den_ff);
               end
               state_ff <= ST_OUT;
            end
            ST_OUT: if (!hold_w) begin
               // advance the finished word into the output register
               rsp_ff       <= res_ff;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

// ----- hw/rtl/rau_checker.sv -----
// Port-level checker for the rational arithmetic unit, bound to the top level.
`include "rational_arithmetic_unit_macros.svh"
module rau_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input rau_pkg::rsp_type rsp_data
);
   logic err_w;
   assign err_w = rsp_valid && rsp_data.error_code != rau_pkg::ERR_OK;

   `RAU_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `RAU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `RAU_ASSERT_IMP(a_cmp_no_num, clock, reset, rsp_valid && rsp_data.cmp_true, rsp_data.res_den == '0)
   `RAU_ASSERT_IMP(a_err_zero, clock, reset, err_w, rsp_data.res_den == '0)
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
